[design/fnpll_pkg.sv]
// ----------------------------------------------------------------------------
// fnpll_pkg
// shared types and constants of the fractional-n pll register planner
// ----------------------------------------------------------------------------
package fnpll_pkg;

  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 30;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_RANGE_ERR = 3'd1;
  localparam status_t ST_CFG_ERR   = 3'd2;
  localparam status_t ST_INT_ERR   = 3'd3;
  localparam status_t ST_PFD_ERR   = 3'd4;

  typedef enum logic [2:0] {
    CFG_REF_FREQ  = 3'd0,
    CFG_REF_TRIM  = 3'd1,
    CFG_REF_PATH  = 3'd2,
    CFG_REF_DIV   = 3'd3,
    CFG_PUMP      = 3'd4,
    CFG_OUT_POWER = 3'd5,
    CFG_OUT_FLAGS = 3'd6
  } cfg_index_t;

  localparam logic [32:0] FREQ_MIN_HZ      = 33'd34375000;
  localparam logic [32:0] FREQ_MAX_HZ      = 33'd4400000000;
  localparam logic [32:0] VCO_MIN_HZ       = 33'd2200000000;
  localparam logic [32:0] VCO_MAX_HZ       = 33'd4400000000;
  localparam logic [32:0] PRESC89_ABOVE_HZ = 33'd3600000000;
  localparam logic [29:0] PFD_MAX_FRAC_HZ  = 30'd32000000;
  localparam logic [29:0] PFD_MAX_INT_HZ   = 30'd90000000;
  localparam logic [29:0] PPB_SCALE        = 30'd1000000000;
  localparam logic [16:0] INT_MIN_89       = 17'd75;
  localparam logic [16:0] INT_MIN_45       = 17'd23;
  localparam logic [16:0] INT_MAX          = 17'd65535;
  localparam logic [11:0] MOD_MAX          = 12'd4095;
  localparam logic [11:0] MOD_INT_N        = 12'd2;
  localparam logic [2:0]  OUT_DIV_MAX      = 3'd6;
  localparam logic [31:0] WORD5_VALUE      = 32'h0058_0005;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_TRIM_MUL, S_TRIM_DIV, S_TRIM_WAIT, S_PFD_DIV, S_PFD_WAIT,
    S_VCO, S_INT_DIV, S_INT_WAIT, S_GCD, S_GSHIFT, S_MOD_DIV, S_MOD_WAIT,
    S_FRAC_DIV, S_FRAC_WAIT, S_RND_MUL, S_RND_DIV, S_RND_WAIT, S_EVAL
  } plan_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

[design/fnpll_div.sv]
// ----------------------------------------------------------------------------
// fnpll_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fnpll_div (
  input  logic                clk,
  input  logic                rst,
  input  fnpll_pkg::div_req_t req,
  output fnpll_pkg::div_rsp_t rsp
);

  localparam int unsigned NumW = fnpll_pkg::DIV_NUM_W;
  localparam int unsigned DenW = fnpll_pkg::DIV_DEN_W;
  localparam int unsigned CntW = $clog2(NumW);

  logic            busy;
  logic            done;
  logic [CntW-1:0] cnt;
  logic [NumW-1:0] num;
  logic [DenW-1:0] rem;
  logic [DenW-1:0] den;
  logic [DenW:0]   trial;
  logic            fits;

  assign trial = {rem, num[NumW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      num <= req.dividend;
      den <= req.divisor;
      rem <= '0;
      cnt <= CntW'(NumW - 1);
    end else if (busy) begin
      // shift in one dividend bit, try to subtract
      if (fits) begin
        rem <= DenW'(trial - {1'b0, den});
      end else begin
        rem <= trial[DenW-1:0];
      end
      num <= {num[NumW-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = num;
  assign rsp.rem  = rem;

endmodule

[design/frac_n_pll_register_planner.sv]
// ----------------------------------------------------------------------------
// frac_n_pll_register_planner
// plans int, frac, mod and the six synthesizer register words for a wanted
// output frequency
// ----------------------------------------------------------------------------
//
// channel   direction  beat contents
// s_*       in         tdata[32:0] target_freq
// m_*       out        tdata: status, word0..word5, vco_freq, pfd_freq
// cfg_*     in         cfg_index selects register, cfg_data holds the value
//
// one item at a time; each division runs on the bit-serial divider (a start step,
// 48 quotient bits, then a done pulse)
// a fractional plan runs five divisions plus the binary gcd loop (one step a
// cycle) and its shifts back
// an integer-n plan stops after three divisions; a target out of range or a
// zero r counter goes from the check straight to the result
// the next item is taken once the result sits in the output register; a result
// still waiting there holds the sequencer in its last step
// rst is synchronous; configuration writes are always taken
//
module frac_n_pll_register_planner (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // [32:0] target_freq
  output logic         m_tvalid,
  input  logic         m_tready,
  // [2:0] status, [34:3] word0, [66:35] word1, [98:67] word2, [130:99] word3,
  // [162:131] word4, [194:163] word5, [227:195] vco_freq, [256:228] pfd_freq
  output logic [263:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [27:0]  cfg_data
);

  localparam int unsigned NumW = fnpll_pkg::DIV_NUM_W;
  localparam int unsigned DenW = fnpll_pkg::DIV_DEN_W;

  // configuration registers
  logic [27:0]        ref_freq;
  logic signed [20:0] ref_trim_ppb;
  logic [1:0]         ref_path_flags;
  logic [9:0]         ref_divider;
  logic [3:0]         pump_current_code;
  logic [1:0]         out_power_code;
  logic [1:0]         out_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq          <= 28'd25000000;
      ref_trim_ppb      <= '0;
      ref_path_flags    <= '0;
      ref_divider       <= 10'd1;
      pump_current_code <= 4'd7;
      out_power_code    <= 2'd3;
      out_flags         <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fnpll_pkg::CFG_REF_FREQ:  ref_freq          <= cfg_data;
        fnpll_pkg::CFG_REF_TRIM:  ref_trim_ppb      <= $signed(cfg_data[20:0]);
        fnpll_pkg::CFG_REF_PATH:  ref_path_flags    <= cfg_data[1:0];
        fnpll_pkg::CFG_REF_DIV:   ref_divider       <= cfg_data[9:0];
        fnpll_pkg::CFG_PUMP:      pump_current_code <= cfg_data[3:0];
        fnpll_pkg::CFG_OUT_POWER: out_power_code    <= cfg_data[1:0];
        fnpll_pkg::CFG_OUT_FLAGS: out_flags         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sequencer state and working registers
  fnpll_pkg::plan_state_t state, state_next;
  fnpll_pkg::div_req_t    div_req;
  fnpll_pkg::div_rsp_t    div_rsp;

  logic [32:0]          f_reg;
  fnpll_pkg::status_t   err;
  logic [NumW-1:0]      prod;
  logic                 trim_neg;
  logic [28:0]          cref;
  logic [29:0]          pfd;
  logic [32:0]          vco;
  logic [2:0]           dsel;
  logic [16:0]          ival;
  logic [29:0]          rem_r;
  logic [29:0]          ga;
  logic [29:0]          gb;
  logic [4:0]           gk;
  logic [11:0]          mod_r;
  logic [11:0]          frac_r;

  logic                 out_valid;
  logic [263:0]         out_data;
  logic                 out_free;

  logic                 dbl;
  logic                 half;
  logic [20:0]          trim_mag;
  logic signed [30:0]   cref_sum;
  logic [18:0]          trim_q;

  assign dbl      = ref_path_flags[1];
  assign half     = ref_path_flags[0];
  assign trim_mag = ref_trim_ppb[20] ? 21'(-ref_trim_ppb) : ref_trim_ppb;
  assign trim_q   = div_rsp.quot[18:0];
  assign cref_sum = trim_neg ? $signed({3'b0, ref_freq}) - $signed({12'b0, trim_q})
                             : $signed({3'b0, ref_freq}) + $signed({12'b0, trim_q});
  assign out_free = !out_valid || m_tready;

  fnpll_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fnpll_pkg::S_IDLE: if (s_tvalid) state_next = fnpll_pkg::S_CHECK;
      fnpll_pkg::S_CHECK: begin
        if (f_reg < fnpll_pkg::FREQ_MIN_HZ || f_reg > fnpll_pkg::FREQ_MAX_HZ ||
            ref_divider == '0) begin
          state_next = fnpll_pkg::S_EVAL;
        end else begin
          state_next = fnpll_pkg::S_TRIM_MUL;
        end
      end
      fnpll_pkg::S_TRIM_MUL: state_next = fnpll_pkg::S_TRIM_DIV;
      fnpll_pkg::S_TRIM_DIV: state_next = fnpll_pkg::S_TRIM_WAIT;
      fnpll_pkg::S_TRIM_WAIT: if (div_rsp.done) state_next = fnpll_pkg::S_PFD_DIV;
      fnpll_pkg::S_PFD_DIV: state_next = fnpll_pkg::S_PFD_WAIT;
      fnpll_pkg::S_PFD_WAIT: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quot == '0) ? fnpll_pkg::S_EVAL : fnpll_pkg::S_VCO;
        end
      end
      fnpll_pkg::S_VCO: begin
        if (!(vco < fnpll_pkg::VCO_MIN_HZ && dsel < fnpll_pkg::OUT_DIV_MAX)) begin
          if (vco < fnpll_pkg::VCO_MIN_HZ || vco > fnpll_pkg::VCO_MAX_HZ) begin
            state_next = fnpll_pkg::S_EVAL;
          end else begin
            state_next = fnpll_pkg::S_INT_DIV;
          end
        end
      end
      fnpll_pkg::S_INT_DIV: state_next = fnpll_pkg::S_INT_WAIT;
      fnpll_pkg::S_INT_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot[NumW-1:16] != '0 || div_rsp.rem == '0) begin
            state_next = fnpll_pkg::S_EVAL;
          end else begin
            state_next = fnpll_pkg::S_GCD;
          end
        end
      end
      fnpll_pkg::S_GCD: if (ga == gb) state_next = fnpll_pkg::S_GSHIFT;
      fnpll_pkg::S_GSHIFT: if (gk == '0) state_next = fnpll_pkg::S_MOD_DIV;
      fnpll_pkg::S_MOD_DIV: state_next = fnpll_pkg::S_MOD_WAIT;
      fnpll_pkg::S_MOD_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot[NumW-1:12] == '0 && div_rsp.quot[11:0] >= 12'd2) begin
            state_next = fnpll_pkg::S_FRAC_DIV;
          end else begin
            state_next = fnpll_pkg::S_RND_MUL;
          end
        end
      end
      fnpll_pkg::S_FRAC_DIV: state_next = fnpll_pkg::S_FRAC_WAIT;
      fnpll_pkg::S_FRAC_WAIT: if (div_rsp.done) state_next = fnpll_pkg::S_EVAL;
      fnpll_pkg::S_RND_MUL: state_next = fnpll_pkg::S_RND_DIV;
      fnpll_pkg::S_RND_DIV: state_next = fnpll_pkg::S_RND_WAIT;
      fnpll_pkg::S_RND_WAIT: if (div_rsp.done) state_next = fnpll_pkg::S_EVAL;
      fnpll_pkg::S_EVAL: if (out_free) state_next = fnpll_pkg::S_IDLE;
      default: state_next = fnpll_pkg::S_IDLE;
    endcase
  end

  // divider requests and input handshake
  always_comb begin
    s_tready         = (state == fnpll_pkg::S_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = fnpll_pkg::PPB_SCALE;
    unique case (state)
      fnpll_pkg::S_TRIM_DIV: begin
        div_req.start = 1'b1;
      end
      fnpll_pkg::S_PFD_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = NumW'(dbl ? {cref, 1'b0} : {1'b0, cref});
        div_req.divisor  = DenW'(half ? {ref_divider, 1'b0} : {1'b0, ref_divider});
      end
      fnpll_pkg::S_INT_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = NumW'(vco);
        div_req.divisor  = pfd;
      end
      fnpll_pkg::S_MOD_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = NumW'(pfd);
        div_req.divisor  = ga;
      end
      fnpll_pkg::S_FRAC_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = NumW'(rem_r);
        div_req.divisor  = ga;
      end
      fnpll_pkg::S_RND_DIV: begin
        div_req.start    = 1'b1;
        div_req.divisor  = pfd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fnpll_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      fnpll_pkg::S_IDLE: begin
        f_reg  <= s_tdata[32:0];
        err    <= fnpll_pkg::ST_OK;
        mod_r  <= fnpll_pkg::MOD_INT_N;
        frac_r <= '0;
      end
      fnpll_pkg::S_CHECK: begin
        if (f_reg < fnpll_pkg::FREQ_MIN_HZ || f_reg > fnpll_pkg::FREQ_MAX_HZ) begin
          err <= fnpll_pkg::ST_RANGE_ERR;
        end else if (ref_divider == '0) begin
          err <= fnpll_pkg::ST_CFG_ERR;
        end
      end
      fnpll_pkg::S_TRIM_MUL: begin
        // magnitude product, sign applied after the divide (truncation toward zero)
        prod     <= NumW'({20'd0, ref_freq} * trim_mag);
        trim_neg <= ref_trim_ppb[20];
      end
      fnpll_pkg::S_TRIM_WAIT: begin
        if (div_rsp.done) begin
          cref <= cref_sum[30] ? '0 : cref_sum[28:0];
        end
      end
      fnpll_pkg::S_PFD_WAIT: begin
        if (div_rsp.done) begin
          pfd  <= div_rsp.quot[29:0];
          vco  <= f_reg;
          dsel <= '0;
          if (div_rsp.quot == '0) err <= fnpll_pkg::ST_CFG_ERR;
        end
      end
      fnpll_pkg::S_VCO: begin
        if (vco < fnpll_pkg::VCO_MIN_HZ && dsel < fnpll_pkg::OUT_DIV_MAX) begin
          vco  <= {vco[31:0], 1'b0};
          dsel <= dsel + 1'b1;
        end else if (vco < fnpll_pkg::VCO_MIN_HZ || vco > fnpll_pkg::VCO_MAX_HZ) begin
          err <= fnpll_pkg::ST_RANGE_ERR;
        end
      end
      fnpll_pkg::S_INT_WAIT: begin
        if (div_rsp.done) begin
          ival  <= {1'b0, div_rsp.quot[15:0]};
          rem_r <= div_rsp.rem;
          ga    <= pfd;
          gb    <= div_rsp.rem;
          gk    <= '0;
          if (div_rsp.quot[NumW-1:16] != '0) err <= fnpll_pkg::ST_INT_ERR;
        end
      end
      fnpll_pkg::S_GCD: begin
        // binary gcd, one step a cycle
        if (ga != gb) begin
          if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 1'b1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga > gb) begin
            ga <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
      end
      fnpll_pkg::S_GSHIFT: begin
        if (gk != '0) begin
          ga <= {ga[28:0], 1'b0};
          gk <= gk - 1'b1;
        end
      end
      fnpll_pkg::S_MOD_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot[NumW-1:12] == '0 && div_rsp.quot[11:0] >= 12'd2) begin
            mod_r <= div_rsp.quot[11:0];
          end else begin
            mod_r <= fnpll_pkg::MOD_MAX;
          end
        end
      end
      fnpll_pkg::S_FRAC_WAIT: begin
        if (div_rsp.done) frac_r <= div_rsp.quot[11:0];
      end
      fnpll_pkg::S_RND_MUL: begin
        prod <= NumW'({12'd0, rem_r} * fnpll_pkg::MOD_MAX) + NumW'(pfd[29:1]);
      end
      fnpll_pkg::S_RND_WAIT: begin
        if (div_rsp.done) begin
          // rounding up to a full mod carries into int
          if (div_rsp.quot[11:0] == fnpll_pkg::MOD_MAX) begin
            frac_r <= '0;
            ival   <= ival + 1'b1;
          end else begin
            frac_r <= div_rsp.quot[11:0];
          end
        end
      end
      default: ;
    endcase
  end

  // final checks and word packing
  logic               presc;
  logic               intn;
  logic [16:0]        imin;
  fnpll_pkg::status_t st_fin;
  logic [31:0]        w0, w1, w2, w3, w4;

  always_comb begin
    presc  = vco > fnpll_pkg::PRESC89_ABOVE_HZ;
    imin   = presc ? fnpll_pkg::INT_MIN_89 : fnpll_pkg::INT_MIN_45;
    intn   = (frac_r == '0);
    st_fin = err;
    if (err == fnpll_pkg::ST_OK) begin
      if (ival < imin || ival > fnpll_pkg::INT_MAX) begin
        st_fin = fnpll_pkg::ST_INT_ERR;
      end else if ((!intn && pfd > fnpll_pkg::PFD_MAX_FRAC_HZ) ||
                   (intn && pfd > fnpll_pkg::PFD_MAX_INT_HZ)) begin
        st_fin = fnpll_pkg::ST_PFD_ERR;
      end
    end
    w0 = {1'b0, ival[15:0], frac_r, 3'd0};
    w1 = {4'd0, presc, 11'd0, 1'b1, mod_r, 3'd1};
    w2 = {3'd0, 3'd6, dbl, half, ref_divider, 1'b0, pump_current_code,
          intn, intn, 1'b1, 6'd2};
    w3 = {8'd0, 1'b1, intn, intn, 17'd0, 1'b1, 3'd3};
    w4 = {8'd0, 1'b1, dsel, 8'd50, 1'b0, out_flags[1], 4'd0, out_flags[0],
          out_power_code, 3'd4};
  end

  // output register, frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == fnpll_pkg::S_EVAL && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fnpll_pkg::S_EVAL && out_free) begin
      if (st_fin == fnpll_pkg::ST_OK) begin
        out_data <= {7'd0, pfd[28:0], vco, fnpll_pkg::WORD5_VALUE, w4, w3, w2, w1, w0,
                     st_fin};
      end else begin
        out_data <= {261'd0, st_fin};
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // error results carry all-zero words
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != fnpll_pkg::ST_OK |-> m_tdata[263:3] == '0)
    else $error("error result with nonzero payload");

  // a good plan always has a nonzero pfd and a vco at or above the band's lower edge
  a_ok_band: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == fnpll_pkg::ST_OK |->
      m_tdata[256:228] != '0 && m_tdata[227:195] >= fnpll_pkg::VCO_MIN_HZ)
    else $error("ok result outside vco band or with zero pfd");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

endmodule

[verif/frac_n_pll_plan_checker.sv]
// ----------------------------------------------------------------------------
// frac_n_pll_plan_checker
// watches the target, result and register channels of the pll register
// planner, works out the expected register words and compares each result
// ----------------------------------------------------------------------------
module frac_n_pll_plan_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [39:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [263:0] m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [27:0]  cfg_data,
  output int unsigned  pending,
  output int unsigned  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    fnpll_pkg::status_t status;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [31:0] word4;
    logic [31:0] word5;
    logic [32:0] vco_freq;
    logic [28:0] pfd_freq;
  } plan_t;

  // local copy of the register file
  logic [27:0]   ref_hz;
  longint        trim_ppb;
  logic [1:0]    path_flags;
  logic [9:0]    r_count;
  logic [3:0]    pump_code;
  logic [1:0]    power_code;
  logic [1:0]    rf_flags;

  plan_t planned_q[$];

  function automatic plan_t plan_target(input logic [32:0] f);
    longint          rs, corr, sum;
    longint unsigned refc, pfd, vco, nint, rem, x, y, t, g, m;
    logic [31:0]     div_sel, ival, frac, modv, presc, imin, intn, dbl, half;
    plan_t           p;
    p = '0;
    dbl = {31'b0, path_flags[1]};
    half = {31'b0, path_flags[0]};
    if (f < fnpll_pkg::FREQ_MIN_HZ || f > fnpll_pkg::FREQ_MAX_HZ) begin
      p.status = fnpll_pkg::ST_RANGE_ERR;
      return p;
    end
    if (r_count == 0) begin
      p.status = fnpll_pkg::ST_CFG_ERR;
      return p;
    end
    rs = longint'({36'b0, ref_hz});
    corr = (rs * trim_ppb) / 64'sd1000000000;
    sum = rs + corr;
    refc = (sum < 0) ? 64'd0 : longint'(sum);
    pfd = (refc * (dbl ? 2 : 1)) / (longint'({54'b0, r_count}) * (half ? 2 : 1));
    if (pfd == 0) begin
      p.status = fnpll_pkg::ST_CFG_ERR;
      return p;
    end
    // smallest power-of-two output divider that lifts the vco into band
    vco = {31'b0, f};
    div_sel = 0;
    while (vco < 64'd2200000000 && div_sel < 6) begin
      vco = vco << 1;
      div_sel++;
    end
    if (vco < 64'd2200000000 || vco > 64'd4400000000) begin
      p.status = fnpll_pkg::ST_RANGE_ERR;
      return p;
    end
    nint = vco / pfd;
    rem = vco % pfd;
    if (nint > 65535) begin
      p.status = fnpll_pkg::ST_INT_ERR;
      return p;
    end
    ival = nint[31:0];
    frac = 0;
    modv = 2;
    if (rem != 0) begin
      x = pfd;
      y = rem;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      g = x;
      m = pfd / g;
      if (m >= 2 && m <= 4095) begin
        modv = m[31:0];
        frac = 32'(rem / g);
      end else begin
        // no exact fraction fits, round onto the largest modulus
        modv = 4095;
        frac = 32'((rem * 4095 + pfd / 2) / pfd);
        if (frac >= modv) begin
          frac = 0;
          ival = ival + 1;
        end
      end
    end
    presc = (vco > 64'd3600000000) ? 1 : 0;
    imin = presc ? 75 : 23;
    if (ival < imin || ival > 65535) begin
      p.status = fnpll_pkg::ST_INT_ERR;
      return p;
    end
    intn = (frac == 0) ? 1 : 0;
    if ((!intn && pfd > 32000000) || (intn && pfd > 90000000)) begin
      p.status = fnpll_pkg::ST_PFD_ERR;
      return p;
    end
    p.status = fnpll_pkg::ST_OK;
    p.word0 = (ival << 15) | (frac << 3);
    p.word1 = (presc << 27) | (32'd1 << 15) | (modv << 3) | 32'd1;
    p.word2 = (32'd6 << 26) | (dbl << 25) | (half << 24) | ({22'b0, r_count} << 14) |
              ({28'b0, pump_code} << 9) | (intn << 8) | (intn << 7) | (32'd1 << 6) | 32'd2;
    p.word3 = (32'd1 << 23) | (intn << 22) | (intn << 21) | (32'd1 << 3) | 32'd3;
    p.word4 = (32'd1 << 23) | (div_sel << 20) | (32'd50 << 12) |
              ({31'b0, rf_flags[1]} << 10) | ({31'b0, rf_flags[0]} << 5) |
              ({30'b0, power_code} << 3) | 32'd4;
    p.word5 = 32'h0058_0005;
    p.vco_freq = vco[32:0];
    p.pfd_freq = pfd[28:0];
    return p;
  endfunction

  function automatic int field_ok(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      return 0;
    end
    return 1;
  endfunction

  assign pending = planned_q.size();

  always @(posedge clk) begin
    plan_t want;
    int    ok;
    if (rst) begin
      ref_hz     <= 28'd25000000;
      trim_ppb   <= 0;
      path_flags <= 2'd0;
      r_count    <= 10'd1;
      pump_code  <= 4'd7;
      power_code <= 2'd3;
      rf_flags   <= 2'd1;
      planned_q.delete();
      fail_count <= 0;
    end else begin
      // writes must happen only while idle (the planner does not enforce it), so ordering against beats is moot
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fnpll_pkg::CFG_REF_FREQ:  ref_hz <= cfg_data;
          fnpll_pkg::CFG_REF_TRIM:  trim_ppb <= longint'($signed(cfg_data[20:0]));
          fnpll_pkg::CFG_REF_PATH:  path_flags <= cfg_data[1:0];
          fnpll_pkg::CFG_REF_DIV:   r_count <= cfg_data[9:0];
          fnpll_pkg::CFG_PUMP:      pump_code <= cfg_data[3:0];
          fnpll_pkg::CFG_OUT_POWER: power_code <= cfg_data[1:0];
          fnpll_pkg::CFG_OUT_FLAGS: rf_flags <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        planned_q.push_back(plan_target(s_tdata[32:0]));
      if (m_tvalid && m_tready) begin
        if (planned_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = planned_q.pop_front();
          ok = 1;
          ok &= field_ok("status", 64'(want.status), 64'(m_tdata[2:0]));
          ok &= field_ok("word0", 64'(want.word0), 64'(m_tdata[34:3]));
          ok &= field_ok("word1", 64'(want.word1), 64'(m_tdata[66:35]));
          ok &= field_ok("word2", 64'(want.word2), 64'(m_tdata[98:67]));
          ok &= field_ok("word3", 64'(want.word3), 64'(m_tdata[130:99]));
          ok &= field_ok("word4", 64'(want.word4), 64'(m_tdata[162:131]));
          ok &= field_ok("word5", 64'(want.word5), 64'(m_tdata[194:163]));
          ok &= field_ok("vco_freq", 64'(want.vco_freq), 64'(m_tdata[227:195]));
          ok &= field_ok("pfd_freq", 64'(want.pfd_freq), 64'(m_tdata[256:228]));
          if (!ok)
            fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

[verif/frac_n_pll_register_planner_tb.sv]
// ----------------------------------------------------------------------------
// frac_n_pll_register_planner_tb
// drives target frequencies through several reference setups, with bursty
// input and a stalling result side; the checker predicts every beat
// ----------------------------------------------------------------------------
module frac_n_pll_register_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;   // [32:0] target_freq
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [263:0] m_tdata;        // status, word0..word5, vco_freq, pfd_freq
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = fnpll_pkg::CFG_REF_FREQ;
  logic [27:0]  cfg_data = '0;
  int unsigned  pending;
  int unsigned  fail_count;

  // burst bookkeeping for the target side
  int unsigned  burst_left = 0;
  // result side stall pattern
  int unsigned  stall_mode = 0;
  int unsigned  stall_tick = 0;

  always #5 clk = ~clk;

  frac_n_pll_register_planner u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  frac_n_pll_plan_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  // result side: each time stall_tick wraps, pick always-ready, random or periodic stalls
  always @(posedge clk) begin
    if (stall_tick == 0)
      stall_mode <= $urandom_range(0, 2);
    stall_tick <= (stall_tick + 1) % 64;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (stall_tick % 5 != 0);
    endcase
  end

  // one register write; ready is sampled at the falling edge to stay race free
  task automatic write_reg(input fnpll_pkg::cfg_index_t idx, input logic [27:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setup(input logic [27:0] ref_hz, input int trim,
                            input logic [1:0] path, input logic [9:0] r_count,
                            input logic [3:0] pump, input logic [1:0] power,
                            input logic [1:0] rf_flags);
    logic [20:0] trim_bits;
    trim_bits = 21'(trim);
    write_reg(fnpll_pkg::CFG_REF_FREQ, ref_hz);
    write_reg(fnpll_pkg::CFG_REF_TRIM, {7'b0, trim_bits});
    write_reg(fnpll_pkg::CFG_REF_PATH, {26'b0, path});
    write_reg(fnpll_pkg::CFG_REF_DIV, {18'b0, r_count});
    write_reg(fnpll_pkg::CFG_PUMP, {24'b0, pump});
    write_reg(fnpll_pkg::CFG_OUT_POWER, {26'b0, power});
    write_reg(fnpll_pkg::CFG_OUT_FLAGS, {26'b0, rf_flags});
  endtask

  // one target beat, then maybe a gap when the current burst runs out
  task automatic send_target(input logic [32:0] f);
    s_tdata  <= {7'b0, f};
    s_tvalid <= 1'b1;
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 1)) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // drain between phases, with slack for the block to settle
  task automatic drain();
    @(posedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [32:0] pick_target();
    int unsigned sel;
    longint unsigned step, f;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      return 33'({$urandom_range(0, 1), $urandom()});   // anywhere in the field
    if (sel <= 4) begin
      // round steps give exact fractions and integer-n plans
      case ($urandom_range(0, 3))
        0: step = 1000000;
        1: step = 100000;
        2: step = 12500;
        default: step = 5000000;
      endcase
      f = step * $urandom_range(34375000 / step + 1, 64'd4400000000 / step);
      return f[32:0];
    end
    f = 34375000 + ({$urandom_range(0, 1), $urandom()} % 64'd4365625001);
    return f[32:0];
  endfunction

  initial begin
    #30ms;
    $display("frac_n_pll_register_planner verification failed");
    $finish;
  end

  initial begin
    logic [32:0] directed[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values written explicitly
    load_setup(28'd25000000, 0, 2'd0, 10'd1, 4'd7, 2'd3, 2'd1);
    directed = '{33'd0, 33'd34374999, 33'd34375000, 33'd68750000, 33'd4400000000,
                 33'd4400000001, 33'h1_FFFF_FFFF, 33'd2200000000, 33'd2199999999,
                 33'd3600000000, 33'd3600000001, 33'd100000000, 33'd1000000001,
                 33'd2499999999, 33'd2400012500, 33'd1466666667, 33'd4399999999};
    foreach (directed[i]) send_target(directed[i]);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_setup(28'd250000000, 1000000, 2'd3, 10'd1023, 4'd0, 2'd0, 2'd0);
        1: load_setup(28'd10000, -1000000, 2'd0, 10'd1, 4'd15, 2'd1, 2'd3);
        2: load_setup(28'd250000000, 0, 2'd2, 10'd3, 4'd3, 2'd2, 2'd2);
        3: load_setup(28'd0, 0, 2'd1, 10'd1, 4'd9, 2'd3, 2'd1);
        4: load_setup(28'd25000000, 0, 2'd0, 10'd0, 4'd7, 2'd3, 2'd1);
        5: load_setup(28'd100000000, -1000000, 2'd1, 10'd4, 4'd5, 2'd1, 2'd1);
        default:
          load_setup(28'($urandom_range(1000000, 250000000)),
                     $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 2000000)) - 1000000
                                               : int'($urandom_range(0, 200)) - 100,
                     2'($urandom_range(0, 3)), 10'($urandom_range(1, 40)),
                     4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)));
      endcase
      repeat (113) send_target(pick_target());
      drain();
    end

    // every item gives a result; leave room for anything stray to show up
    repeat (600) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("frac_n_pll_register_planner verification clean");
    else
      $display("frac_n_pll_register_planner verification failed");
    $finish;
  end

endmodule
